/* sv/playback_feedback_rate_controller_assert.svh */
// Assertion macros for the playback feedback rate controller checker.
`ifndef PLAYBACK_FEEDBACK_RATE_CONTROLLER_ASSERT_SVH
`define PLAYBACK_FEEDBACK_RATE_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PFRC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pfrc check failed");

// next-cycle implication, disabled while reset is asserted
`define PFRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pfrc check failed");

`endif

/* sv/pfrc_pkg.sv */
// Shared types, constants and codes for the playback feedback rate controller.
package pfrc_pkg;

    localparam int BUFFER_SIZE = 512;
    localparam int TWO_THIRDS  = (BUFFER_SIZE * 2) / 3;

    localparam int IDX_W   = 14;
    localparam int REM_W   = 15;
    localparam int BYTES_W = 10;
    localparam int GAP_SW  = 18;   // signed working width of the gap math

    // x / 6 for 10-bit x: (x * 683) >> 12, exact over 0..1023
    localparam int DIV6_MUL   = 683;
    localparam int DIV6_SHIFT = 12;
    localparam int PROD_W     = BYTES_W + DIV6_SHIFT - 2;   // 20 bits
    localparam int FRAMES_W   = PROD_W - DIV6_SHIFT;        // 8 bits

    localparam logic [31:0] NOMINAL_RATE_RST   = 32'd786432;   // 48 << 14
    localparam logic [15:0] RATE_STEP_RST      = 16'd4096;
    localparam logic [2:0]  STEP_LIMIT_RST     = 3'd2;
    localparam logic [12:0] PLL_STEP_LIMIT_RST = 13'd5000;
    localparam logic [7:0]  GAP_DEADBAND_RST   = 8'd10;

    localparam logic [2:0] FB_BYTES_NONE = 3'd0;
    localparam logic [2:0] FB_BYTES_FS   = 3'd3;
    localparam logic [2:0] FB_BYTES_HS   = 3'd4;

    typedef enum logic [1:0] {
        KIND_FEEDBACK = 2'd0,
        KIND_PACKET   = 2'd1,
        KIND_STOP     = 2'd2,
        KIND_RESTART  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PLL_NONE  = 2'd0,
        PLL_RAISE = 2'd1,
        PLL_LOWER = 2'd2
    } pll_req_t;

    typedef enum logic [2:0] {
        CFG_NOMINAL_RATE   = 3'd0,
        CFG_RATE_STEP      = 3'd1,
        CFG_STEP_LIMIT     = 3'd2,
        CFG_PLL_STEP_LIMIT = 3'd3,
        CFG_GAP_DEADBAND   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] nominal_rate;
        logic [15:0] rate_step;
        logic [2:0]  step_limit;
        logic [12:0] pll_step_limit;
        logic [7:0]  gap_deadband;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [REM_W-1:0]    dma_remaining;
        logic                dma_bank;
        logic                full_speed;
        logic [BYTES_W-1:0]  byte_count;
    } item_t;

    typedef struct packed {
        logic [31:0]      feedback_value;
        logic [2:0]       feedback_bytes;
        pll_req_t         pll_request;
        logic [15:0]      buffer_gap;
        logic [IDX_W-1:0] write_position;
        logic             write_bank;
    } result_t;

endpackage

/* sv/pfrc_cfg_regs.sv */
// Configuration register bank written over the config transfer channel.
module pfrc_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output pfrc_pkg::cfg_t    cfg
);
    import pfrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NOMINAL_RATE:   cfg_next.nominal_rate   = cfg_data;
                CFG_RATE_STEP:      cfg_next.rate_step      = cfg_data[15:0];
                CFG_STEP_LIMIT:     cfg_next.step_limit     = cfg_data[2:0];
                CFG_PLL_STEP_LIMIT: cfg_next.pll_step_limit = cfg_data[12:0];
                CFG_GAP_DEADBAND:   cfg_next.gap_deadband   = cfg_data[7:0];
                default:            cfg_next = cfg_reg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nominal_rate   <= NOMINAL_RATE_RST;
            cfg_reg.rate_step      <= RATE_STEP_RST;
            cfg_reg.step_limit     <= STEP_LIMIT_RST;
            cfg_reg.pll_step_limit <= PLL_STEP_LIMIT_RST;
            cfg_reg.gap_deadband   <= GAP_DEADBAND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/pfrc_core.sv */
// Controller state and the per-item gap, rate, PLL and write-point logic.
module pfrc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_fire,
    input  pfrc_pkg::item_t   item,
    input  pfrc_pkg::cfg_t    cfg,
    output pfrc_pkg::result_t result
);
    import pfrc_pkg::*;

    logic [IDX_W-1:0]    write_index_reg, write_index_next;
    logic                write_bank_reg, write_bank_next;
    logic                running_reg, running_next;
    logic signed [3:0]   net_rate_reg, net_rate_next;
    logic [31:0]         rate_reg, rate_next;
    logic signed [13:0]  net_pll_reg, net_pll_next;

    logic [REM_W-1:0]       rem;
    logic signed [GAP_SW-1:0] s_s, r_s, w_s, db_s, gap_s;
    logic signed [4:0]      lim_s, nr_s, nr_upd;
    logic signed [14:0]     plim_s, np_s;
    logic [PROD_W-1:0]      prod;
    logic [FRAMES_W-1:0]    frames;
    logic [REM_W-1:0]       start_pos;
    logic [IDX_W-1:0]       base_idx;
    logic                   base_bank;
    logic [REM_W-1:0]       total;
    logic [REM_W-1:0]       wraps;
    pll_req_t               pll;

    always_comb begin
        rem = (item.dma_remaining > REM_W'(BUFFER_SIZE)) ? REM_W'(BUFFER_SIZE)
                                                         : item.dma_remaining;
        s_s  = GAP_SW'(BUFFER_SIZE);
        r_s  = signed'({3'b000, rem});
        w_s  = signed'({4'b0000, write_index_reg});
        db_s = signed'({10'd0, cfg.gap_deadband});

        // gap from write point to DMA read point across the two banks
        if (write_bank_reg != item.dma_bank) begin
            if (w_s < s_s - r_s) begin
                gap_s = s_s - r_s - w_s;
            end else begin
                gap_s = GAP_SW'(3 * BUFFER_SIZE) - w_s - r_s;
            end
        end else begin
            gap_s = GAP_SW'(2 * BUFFER_SIZE) - w_s - r_s;
        end

        lim_s  = signed'({2'b00, cfg.step_limit});
        nr_s   = 5'(net_rate_reg);
        plim_s = signed'({2'b00, cfg.pll_step_limit});
        np_s   = 15'(net_pll_reg);

        prod   = PROD_W'(item.byte_count) * PROD_W'(DIV6_MUL);
        frames = prod[PROD_W-1:DIV6_SHIFT];

        start_pos = (REM_W'(BUFFER_SIZE) - rem) & ~REM_W'(1);

        write_index_next = write_index_reg;
        write_bank_next  = write_bank_reg;
        running_next     = running_reg;
        net_rate_next    = net_rate_reg;
        rate_next        = rate_reg;
        net_pll_next     = net_pll_reg;
        nr_upd           = nr_s;
        pll              = PLL_NONE;
        base_idx         = write_index_reg;
        base_bank        = write_bank_reg;
        total            = '0;
        wraps            = '0;

        case (item.kind)
            KIND_FEEDBACK: begin
                if (running_reg) begin
                    if (gap_s < s_s - db_s && nr_s > -lim_s) begin
                        rate_next = rate_reg - {16'd0, cfg.rate_step};
                        nr_upd    = nr_s - 5'sd1;
                    end else if (gap_s > s_s + db_s && nr_s < lim_s) begin
                        rate_next = rate_reg + {16'd0, cfg.rate_step};
                        nr_upd    = nr_s + 5'sd1;
                    end
                    // PLL step only once the rate steps are used up
                    if (gap_s < GAP_SW'(BUFFER_SIZE - TWO_THIRDS) && np_s < plim_s
                            && nr_upd <= -lim_s) begin
                        pll          = PLL_RAISE;
                        net_pll_next = 14'(np_s + 15'sd1);
                    end else if (gap_s > GAP_SW'(BUFFER_SIZE + TWO_THIRDS)
                            && np_s > -plim_s && nr_upd >= lim_s) begin
                        pll          = PLL_LOWER;
                        net_pll_next = 14'(np_s - 15'sd1);
                    end
                    net_rate_next = 4'(nr_upd);
                end
            end
            KIND_PACKET: begin
                if (!running_reg) begin
                    running_next  = 1'b1;
                    net_rate_next = '0;
                    if (start_pos >= REM_W'(BUFFER_SIZE)) begin
                        base_idx  = '0;
                        base_bank = ~item.dma_bank;
                    end else begin
                        base_idx  = IDX_W'(start_pos);
                        base_bank = item.dma_bank;
                    end
                end
                // write point is always even, so stepping by two wraps modulo the size
                total = REM_W'(base_idx) + REM_W'({frames, 1'b0});
                wraps = REM_W'(total / BUFFER_SIZE);
                write_index_next = IDX_W'(total % BUFFER_SIZE);
                write_bank_next  = base_bank ^ wraps[0];
            end
            KIND_STOP: begin
                running_next = 1'b0;
            end
            KIND_RESTART: begin
                rate_next     = cfg.nominal_rate;
                net_rate_next = '0;
                net_pll_next  = '0;
                running_next  = 1'b0;
            end
            default: begin
                running_next = running_reg;
            end
        endcase

        result = '0;
        result.write_position = write_index_next;
        result.write_bank     = write_bank_next;
        if (item.kind == KIND_FEEDBACK) begin
            result.pll_request = pll;
            result.buffer_gap  = 16'(gap_s);
            if (item.full_speed) begin
                result.feedback_value = {8'd0, rate_next[23:0]};
                result.feedback_bytes = FB_BYTES_FS;
            end else begin
                result.feedback_value = rate_next;
                result.feedback_bytes = FB_BYTES_HS;
            end
        end else begin
            result.pll_request    = PLL_NONE;
            result.feedback_bytes = FB_BYTES_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_index_reg <= '0;
            write_bank_reg  <= 1'b0;
            running_reg     <= 1'b0;
            net_rate_reg    <= '0;
            rate_reg        <= NOMINAL_RATE_RST;
            net_pll_reg     <= '0;
        end else if (item_fire) begin
            write_index_reg <= write_index_next;
            write_bank_reg  <= write_bank_next;
            running_reg     <= running_next;
            net_rate_reg    <= net_rate_next;
            rate_reg        <= rate_next;
            net_pll_reg     <= net_pll_next;
        end
    end

endmodule

/* sv/playback_feedback_rate_controller.sv */
// Top level: input register, controller core, result register and config bank.
//
//  channel | ports                         | contents
//  --------+-------------------------------+------------------------------------------
//  in      | s_tvalid s_tready s_tdata/user | request kind, DMA count, bank, speed, bytes
//  out     | m_tvalid m_tready m_tdata      | feedback rate/bytes, PLL request, gap, write pt
//  cfg     | cfg_valid cfg_ready            | register index and write data
//
// One item per cycle sustained while m_tready is high; m_tdata is driven by the output register.
// The rate limit is the combinational state update in the core (gap, rate step, PLL step).
// aresetn is synchronous; it clears both valid stages and the controller state.
// A stalled result holds in the output register while one more item waits in the input
// register; input stalls only when both are full.
module playback_feedback_rate_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // dma_remaining[14:0], dma_bank[15], full_speed[16],
                                   // byte_count[26:17], zero[31:27]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // feedback_value[31:0], feedback_bytes[34:32],
                                   // pll_request[36:35], buffer_gap[52:37],
                                   // write_position[66:53], write_bank[67], zero[71:68]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pfrc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t core_result;
    result_t out_result_reg;
    logic    out_valid_reg, out_valid_next;
    logic    s_fire;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.kind          <= kind_t'(s_tuser);
            in_item_reg.dma_remaining <= s_tdata[14:0];
            in_item_reg.dma_bank      <= s_tdata[15];
            in_item_reg.full_speed    <= s_tdata[16];
            in_item_reg.byte_count    <= s_tdata[26:17];
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    pfrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfrc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .item      (in_item_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.write_bank,
                       out_result_reg.write_position,
                       out_result_reg.buffer_gap,
                       out_result_reg.pll_request,
                       out_result_reg.feedback_bytes,
                       out_result_reg.feedback_value};

endmodule

/* sv/pfrc_checker.sv */
// Port-level checker for the playback feedback rate controller, bound to the top level.
`include "playback_feedback_rate_controller_assert.svh"

module pfrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // a stalled result keeps its contents
    `PFRC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // results that are not feedback carry no rate, PLL request or gap
    `PFRC_ASSERT_NOW(a_non_fb_zero, aclk, aresetn, m_tvalid && m_tdata[34:32] == 3'd0, m_tdata[31:0] == 32'd0 && m_tdata[52:35] == 18'd0)

    // full-speed feedback uses only three bytes
    `PFRC_ASSERT_NOW(a_fs_width, aclk, aresetn, m_tvalid && m_tdata[34:32] == 3'd3, m_tdata[31:24] == 8'd0)

    // write point stays on a stereo frame boundary and PLL code is never both ways
    `PFRC_ASSERT_NOW(a_wpos_even, aclk, aresetn, m_tvalid, m_tdata[53] == 1'b0 && m_tdata[36:35] != 2'd3)

endmodule

bind playback_feedback_rate_controller pfrc_checker u_pfrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/playback_feedback_rate_controller_tb.sv */
// Testbench for the playback feedback rate controller: directed and random traffic, self-checked.
`timescale 1ns / 1ps

module playback_feedback_rate_controller_tb;
    import pfrc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // dma_remaining, dma_bank, full_speed, byte_count
    logic [1:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // feedback_value, feedback_bytes, pll_request, buffer_gap,
                                 // write_position, write_bank
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predicted controller state and register copy
    cfg_t             shadow_cfg;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_bank;
    logic             playing;
    int               rate_adj;
    logic [31:0]      fb_rate;
    int               pll_adj;

    result_t     pending_status[$];
    result_t     want_status;
    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    playback_feedback_rate_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic result_t controller_update(item_t it);
        result_t r;
        int      s, rem, w, gap, lim, plim, db, pos, frames, i;
        r = '0;
        s = BUFFER_SIZE;
        rem = (it.dma_remaining > BUFFER_SIZE) ? BUFFER_SIZE : int'(it.dma_remaining);
        case (it.kind)
            KIND_FEEDBACK: begin
                w = int'(wr_idx);
                if (wr_bank != it.dma_bank)
                    gap = (w < s - rem) ? s - rem - w : 3 * s - w - rem;
                else
                    gap = 2 * s - w - rem;
                lim = int'(shadow_cfg.step_limit);
                plim = int'(shadow_cfg.pll_step_limit);
                db = int'(shadow_cfg.gap_deadband);
                if (playing) begin
                    if (gap < s - db && rate_adj > -lim) begin
                        fb_rate = fb_rate - {16'h0000, shadow_cfg.rate_step};
                        rate_adj--;
                    end else if (gap > s + db && rate_adj < lim) begin
                        fb_rate = fb_rate + {16'h0000, shadow_cfg.rate_step};
                        rate_adj++;
                    end
                    // PLL steps only once the rate steps are used up
                    if (gap < s - TWO_THIRDS && pll_adj < plim && rate_adj <= -lim) begin
                        r.pll_request = PLL_RAISE;
                        pll_adj++;
                    end else if (gap > s + TWO_THIRDS && pll_adj > -plim
                            && rate_adj >= lim) begin
                        r.pll_request = PLL_LOWER;
                        pll_adj--;
                    end
                end
                r.buffer_gap = gap[15:0];
                if (it.full_speed) begin
                    r.feedback_value = {8'h00, fb_rate[23:0]};
                    r.feedback_bytes = FB_BYTES_FS;
                end else begin
                    r.feedback_value = fb_rate;
                    r.feedback_bytes = FB_BYTES_HS;
                end
            end
            KIND_PACKET: begin
                frames = int'(it.byte_count) / 6;
                if (!playing) begin
                    pos = (s - rem) & ~1;
                    playing = 1'b1;
                    wr_bank = it.dma_bank;
                    if (pos >= s) begin
                        pos = 0;
                        wr_bank = ~wr_bank;
                    end
                    wr_idx = pos[IDX_W-1:0];
                    rate_adj = 0;
                end
                for (i = 0; i < frames; i++) begin
                    wr_idx = wr_idx + 2'd2;
                    if (wr_idx >= BUFFER_SIZE) begin
                        wr_idx = '0;
                        wr_bank = ~wr_bank;
                    end
                end
            end
            KIND_STOP: playing = 1'b0;
            default: begin
                fb_rate = shadow_cfg.nominal_rate;
                rate_adj = 0;
                pll_adj = 0;
                playing = 1'b0;
            end
        endcase
        r.write_position = wr_idx;
        r.write_bank = wr_bank;
        return r;
    endfunction

    function automatic void apply_register(cfg_idx_t idx, logic [31:0] val);
        case (idx)
            CFG_NOMINAL_RATE:   shadow_cfg.nominal_rate = val;
            CFG_RATE_STEP:      shadow_cfg.rate_step = val[15:0];
            CFG_STEP_LIMIT:     shadow_cfg.step_limit = val[2:0];
            CFG_PLL_STEP_LIMIT: shadow_cfg.pll_step_limit = val[12:0];
            CFG_GAP_DEADBAND:   shadow_cfg.gap_deadband = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic item_t item_of(kind_t k, int rem, bit bank, bit fs, int bytes);
        item_t it;
        it.kind = k;
        it.dma_remaining = rem[REM_W-1:0];
        it.dma_bank = bank;
        it.full_speed = fs;
        it.byte_count = bytes[BYTES_W-1:0];
        return it;
    endfunction

    // bias 1 steers feedback toward a short gap, bias 2 toward a long one
    function automatic item_t random_item(kind_t k, int unsigned bias);
        item_t it;
        int    w, slack, bytes;
        bytes = ($urandom_range(3) == 0) ? int'($urandom_range(1023))
                                         : 6 * int'($urandom_range(170));
        if ($urandom_range(9) == 0)
            it = item_of(k, $urandom_range(16384, 513), 1'($urandom_range(1)),
                         1'($urandom_range(1)), bytes);
        else
            it = item_of(k, $urandom_range(BUFFER_SIZE), 1'($urandom_range(1)),
                         1'($urandom_range(1)), bytes);
        if (k == KIND_FEEDBACK && bias != 0 && playing) begin
            w = int'(wr_idx);
            it.dma_bank = ~wr_bank;
            if (bias == 1) begin
                slack = $urandom_range(60, 1);
                it.dma_remaining = (BUFFER_SIZE - w > slack) ? REM_W'(BUFFER_SIZE - w - slack)
                                                             : '0;
            end else
                it.dma_remaining = REM_W'(BUFFER_SIZE - w
                                          + int'($urandom_range(w < 100 ? w : 100)));
        end
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    task automatic send_item(item_t it);
        @(negedge aclk);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = it.kind;
        s_tdata = {5'b0, it.byte_count, it.full_speed, it.dma_bank, it.dma_remaining};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(controller_update(it));
        items_sent++;
    endtask

    task automatic write_register(cfg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        int unsigned waited;
        @(negedge aclk);
        s_tvalid = 1'b0;
        waited = 0;
        while (pending_status.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // each run: optional restart, a packet to start the player, then mixed traffic
    task automatic run_sessions(int unsigned count);
        int unsigned stop_at, run_len, bias, pick, j;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            bias = $urandom_range(2);
            run_len = $urandom_range(40, 8);
            if ($urandom_range(2) == 0)
                send_item(random_item(KIND_RESTART, 0));
            send_item(random_item(KIND_PACKET, 0));
            for (j = 0; j < run_len; j++) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    send_item(random_item(KIND_FEEDBACK, bias));
                else if (pick < 86)
                    send_item(random_item(KIND_PACKET, 0));
                else if (pick < 90)
                    send_item(random_item(KIND_STOP, 0));
                else if (pick < 93)
                    send_item(random_item(KIND_RESTART, 0));
                else
                    send_item(random_item(kind_t'($urandom_range(3)), 0));
            end
        end
    endtask

    task automatic test_directed_cases();
        int k;
        idle_pct = 20;
        // player stopped: gap only, with the remaining count beyond the buffer clamped
        send_item(item_of(KIND_FEEDBACK, 0, 1'b0, 1'b1, 0));
        send_item(item_of(KIND_FEEDBACK, 16384, 1'b1, 1'b0, 1023));
        send_item(item_of(KIND_FEEDBACK, 16383, 1'b0, 1'b0, 0));
        // start at the buffer end wraps to 0 in the other bank
        send_item(item_of(KIND_PACKET, 0, 1'b0, 1'b0, 0));
        send_item(item_of(KIND_STOP, 0, 1'b1, 1'b1, 1023));
        send_item(item_of(KIND_PACKET, 16384, 1'b1, 1'b0, 1023));
        send_item(item_of(KIND_STOP, 0, 1'b0, 1'b0, 0));
        // odd start offset is aligned down; fewer than six bytes moves nothing
        send_item(item_of(KIND_PACKET, 301, 1'b0, 1'b1, 5));
        // short gap: rate steps down to the limit, then PLL raise
        for (k = 0; k < 4; k++)
            send_item(item_of(KIND_FEEDBACK, BUFFER_SIZE - int'(wr_idx) - 5, ~wr_bank, k[0], 0));
        // long gap: rate steps back up to the limit, then PLL lower
        for (k = 0; k < 6; k++)
            send_item(item_of(KIND_FEEDBACK, BUFFER_SIZE - int'(wr_idx), ~wr_bank, k[0], 6));
        send_item(item_of(KIND_PACKET, 512, 1'b1, 1'b1, 6));
        send_item(item_of(KIND_RESTART, 16384, 1'b1, 1'b1, 1023));
        send_item(item_of(KIND_FEEDBACK, 512, 1'b0, 1'b1, 1023));
        send_item(item_of(KIND_PACKET, 1, 1'b1, 1'b0, 1020));
        drain_results();
    endtask

    task automatic test_register_settings();
        idle_pct = 25;
        run_sessions(220);
        drain_results();
        // top rate, step and step limit, zero PLL limit and deadband; masked registers get junk in the upper bits
        write_register(CFG_NOMINAL_RATE, 32'hFFFF_FFFF);
        write_register(CFG_RATE_STEP, 32'hFFFF_FFFF);
        write_register(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
        write_register(CFG_PLL_STEP_LIMIT, 32'hFFFF_E000);
        write_register(CFG_GAP_DEADBAND, 32'd0);
        idle_pct = 40;
        run_sessions(220);
        drain_results();
        write_register(CFG_NOMINAL_RATE, 32'd0);
        write_register(CFG_RATE_STEP, 32'd1);
        write_register(CFG_STEP_LIMIT, 32'd0);
        write_register(CFG_PLL_STEP_LIMIT, 32'd8191);
        write_register(CFG_GAP_DEADBAND, 32'd255);
        idle_pct = 10;
        run_sessions(220);
        drain_results();
        write_register(CFG_NOMINAL_RATE, $urandom);
        write_register(CFG_RATE_STEP, $urandom_range(65535));
        write_register(CFG_STEP_LIMIT, 32'd1);
        write_register(CFG_PLL_STEP_LIMIT, $urandom_range(4, 1));
        write_register(CFG_GAP_DEADBAND, $urandom_range(255));
        idle_pct = 0;
        run_sessions(220);
        drain_results();
        // limits cut below counts that may already be held
        write_register(CFG_STEP_LIMIT, 32'd3);
        write_register(CFG_PLL_STEP_LIMIT, 32'd1);
        write_register(CFG_RATE_STEP, 32'd4096);
        idle_pct = 30;
        run_sessions(220);
        drain_results();
    endtask

    task automatic test_back_to_back();
        write_register(CFG_NOMINAL_RATE, 32'd786432);
        write_register(CFG_STEP_LIMIT, 32'd2);
        write_register(CFG_PLL_STEP_LIMIT, 32'd5000);
        write_register(CFG_GAP_DEADBAND, 32'd10);
        idle_pct = 0;
        run_sessions(230);
        drain_results();
    endtask

    // receiver stalls in bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 3) begin
            stall_left = $urandom_range(12, 1) - 1;
            m_tready = 1'b0;
        end else
            m_tready = 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0)
                report_mismatch($sformatf("unexpected result 0x%0h", m_tdata));
            else begin
                want_status = pending_status.pop_front();
                compare_field("feedback_value", m_tdata[31:0], want_status.feedback_value);
                compare_field("feedback_bytes", 32'(m_tdata[34:32]),
                              32'(want_status.feedback_bytes));
                compare_field("pll_request", 32'(m_tdata[36:35]),
                              32'(want_status.pll_request));
                compare_field("buffer_gap", 32'(m_tdata[52:37]),
                              32'(want_status.buffer_gap));
                compare_field("write_position", 32'(m_tdata[66:53]),
                              32'(want_status.write_position));
                compare_field("write_bank", 32'(m_tdata[67]),
                              32'(want_status.write_bank));
            end
            results_seen++;
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        shadow_cfg.nominal_rate = NOMINAL_RATE_RST;
        shadow_cfg.rate_step = RATE_STEP_RST;
        shadow_cfg.step_limit = STEP_LIMIT_RST;
        shadow_cfg.pll_step_limit = PLL_STEP_LIMIT_RST;
        shadow_cfg.gap_deadband = GAP_DEADBAND_RST;
        wr_idx = '0;
        wr_bank = 1'b0;
        playing = 1'b0;
        rate_adj = 0;
        fb_rate = NOMINAL_RATE_RST;
        pll_adj = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_register_settings();
        test_back_to_back();

        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
